// ----- design/modbus_read_response_checker_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Modbus read response checker: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_READ_RESPONSE_CHECKER_UNIT_ASSERT_SVH
`define MODBUS_READ_RESPONSE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MBRC_ASSERT_IMP(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define MBRC_ASSERT_NEXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`endif

// ----- design/mbrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_pkg
// Types and constants shared by the Modbus read response checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [8:0]  CTR_MAX  = 9'd511;
	localparam logic [8:0]  HDR_LEN  = 9'd3;
	localparam logic [8:0]  MIN_LEN  = 9'd5;

	localparam logic [7:0] FUNC_READ      = 8'h03;
	localparam logic [7:0] FUNC_EXCEPTION = 8'h83;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_CRC_ERROR = 2'd2;
	localparam logic [1:0] ST_EXCEPTION = 2'd3;

	localparam logic REG_SLAVE_ADDR     = 1'b0;
	localparam logic REG_EXPECTED_COUNT = 1'b1;

	typedef struct packed {
		logic [15:0] crc;
		logic [15:0] held;
		logic [8:0]  len;
	} mbrc_frame_t;

	typedef struct packed {
		logic [7:0] slave;
		logic [7:0] func;
		logic [7:0] count;
	} mbrc_hdr_t;

endpackage

// ----- design/mbrc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_in_if / mbrc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mbrc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;
	logic       end_of_frame;
	logic [6:0] word_index;

	modport source (output valid, mode, rx_byte, end_of_frame, word_index, input ready);
	modport sink (input valid, mode, rx_byte, end_of_frame, word_index, output ready);
endinterface

interface mbrc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [7:0]  exc_byte;
	logic [15:0] reg_word;
	logic        words_valid;

	modport source (output valid, frame_status, exc_byte, reg_word, words_valid,
		input ready);
	modport sink (input valid, frame_status, exc_byte, reg_word, words_valid,
		output ready);
endinterface

// ----- design/mbrc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbrc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 125
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/mbrc_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_frame
// Byte path: two-byte delay, running CRC, length counter, header capture
// and register word assembly with write requests to the word store.
// ----------------------------------------------------------------------------
module mbrc_frame #(
	parameter int MAX_REGISTERS = 125
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [7:0]               rx_byte,
	input  logic                     end_of_frame,
	output logic                     wr_en,
	output logic [(MAX_REGISTERS > 1 ? $clog2(MAX_REGISTERS) : 1)-1:0] wr_addr,
	output logic [15:0]              wr_data,
	output mbrc_pkg::mbrc_frame_t    snap,
	output mbrc_pkg::mbrc_hdr_t      hdr
);
	import mbrc_pkg::*;

	localparam int AW = MAX_REGISTERS > 1 ? $clog2(MAX_REGISTERS) : 1;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [15:0] crc_q;
	logic [8:0]  cnt_q;
	logic [15:0] held_q;
	logic [7:0]  pending_q;
	mbrc_hdr_t   hdr_q;

	logic        shifting;
	logic        known;
	logic [8:0]  pos;
	logic [8:0]  off;
	logic [7:0]  widx;
	logic [15:0] crc_nx;
	logic [15:0] held_nx;
	logic [8:0]  len_nx;
	logic        capture;

	assign shifting = cnt_q >= 9'd2;
	assign known    = cnt_q != CTR_MAX;
	assign pos      = cnt_q - 9'd2;
	assign off      = pos - HDR_LEN;
	assign widx     = off[8:1];
	assign crc_nx   = shifting ? crc_byte(crc_q, held_q[15:8]) : crc_q;
	assign held_nx  = {held_q[7:0], rx_byte};
	assign len_nx   = known ? cnt_q + 9'd1 : cnt_q;
	assign capture  = take && shifting && known;

	assign wr_en   = capture && (pos >= HDR_LEN) && off[0]
		&& ({1'b0, widx} < 9'(MAX_REGISTERS));
	assign wr_addr = widx[AW-1:0];
	assign wr_data = {pending_q, held_q[15:8]};
	assign snap    = '{crc: crc_nx, held: held_nx, len: len_nx};
	assign hdr     = hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_SEED;
			cnt_q     <= '0;
			held_q    <= '0;
			pending_q <= '0;
			hdr_q     <= '0;
		end else begin
			if (take) begin
				if (end_of_frame) begin
					crc_q  <= CRC_SEED;
					cnt_q  <= '0;
					held_q <= '0;
				end else begin
					crc_q  <= crc_nx;
					cnt_q  <= len_nx;
					held_q <= held_nx;
				end
			end
			if (capture) begin
				if (pos == 9'd0) begin
					hdr_q.slave <= held_q[15:8];
				end else if (pos == 9'd1) begin
					hdr_q.func <= held_q[15:8];
				end else if (pos == 9'd2) begin
					hdr_q.count <= held_q[15:8];
				end else if (!off[0]) begin
					pending_q <= held_q[15:8];
				end
			end
		end
	end

endmodule

// ----- design/mbrc_judge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_judge
// End-of-frame checks in priority order, giving status and exception code.
// ----------------------------------------------------------------------------
module mbrc_judge (
	input  mbrc_pkg::mbrc_frame_t snap,
	input  mbrc_pkg::mbrc_hdr_t   hdr,
	input  logic [7:0]            slave_addr,
	input  logic [6:0]            reg_count,
	output logic [1:0]            status,
	output logic [7:0]            exc_code
);
	import mbrc_pkg::*;

	logic [15:0] rx_crc;

	assign rx_crc = {snap.held[7:0], snap.held[15:8]};

	always_comb begin
		exc_code = 8'd0;
		if (snap.len < MIN_LEN) begin
			status = ST_INVALID;
		end else if (rx_crc != snap.crc) begin
			status = ST_CRC_ERROR;
		end else if (hdr.slave != slave_addr) begin
			status = ST_INVALID;
		end else if (hdr.func == FUNC_EXCEPTION) begin
			if (snap.len == MIN_LEN) begin
				status   = ST_EXCEPTION;
				exc_code = hdr.count;
			end else begin
				status = ST_INVALID;
			end
		end else if (hdr.func != FUNC_READ) begin
			status = ST_INVALID;
		end else if (hdr.count != {reg_count, 1'b0}) begin
			status = ST_INVALID;
		end else if (snap.len != ({1'b0, hdr.count} + MIN_LEN)) begin
			status = ST_INVALID;
		end else begin
			status = ST_OK;
		end
	end

endmodule

// ----- design/modbus_read_response_checker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_read_response_checker_unit
// Checks Modbus RTU read-holding-registers responses and serves the words.
// ----------------------------------------------------------------------------
// Items arrive on the item channel: a frame byte (mode 0) or a word read
// (mode 1). A byte without end_of_frame gives no result. A frame's last byte
// gives one status transfer on the result channel; a read gives one transfer
// with the stored word and whether the last frame passed.
// One item is taken per cycle while item.ready is high. An accepted item
// enters the check stage, which holds the word store's registered read and
// the frame checks; its result is then registered in the output register,
// where it waits until the receiver takes it.
// The CRC update runs as a byte-wide unrolled step on the byte leaving the
// two-byte delay when a later byte is taken; completed words are stored then.
// Reset clears the CRC to its seed, the counters, header bytes and the pass
// flag, and sets the expected slave and register count to one. The word
// store is not cleared; words of a failed frame are not meaningful.
// When the receiver stalls, one more result is held in the check stage and
// the item channel then drops ready until the output register drains.
// ----------------------------------------------------------------------------
`include "modbus_read_response_checker_unit_assert.svh"

module modbus_read_response_checker_unit #(
	parameter int MAX_REGISTERS = 125
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	mbrc_in_if.sink     item,
	mbrc_out_if.source  result
);
	import mbrc_pkg::*;

	localparam int AW = MAX_REGISTERS > 1 ? $clog2(MAX_REGISTERS) : 1;

	logic [7:0]  slave_cfg_q;
	logic [6:0]  expected_count_q;

	logic        accept;
	logic        adv;

	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0] wr_data;
	mbrc_frame_t snap;
	mbrc_hdr_t   hdr;
	logic [15:0] rd_data;

	logic        valid_s1;
	logic        is_read_s1;
	logic        oob_s1;
	mbrc_frame_t snap_s1;

	logic [1:0]  status;
	logic [7:0]  exc_code;

	logic        out_valid_q;
	logic [1:0]  frame_status_q;
	logic [7:0]  exc_byte_q;
	logic [15:0] reg_word_q;
	logic        words_valid_q;
	logic        last_ok_q;

	assign adv        = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || adv;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_cfg_q      <= 8'd1;
			expected_count_q <= 7'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLAVE_ADDR:     slave_cfg_q      <= cfg_data;
				REG_EXPECTED_COUNT: expected_count_q <= cfg_data[6:0];
			endcase
		end
	end

	mbrc_frame #(
		.MAX_REGISTERS(MAX_REGISTERS)
	) u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (accept && !item.mode),
		.rx_byte     (item.rx_byte),
		.end_of_frame(item.end_of_frame),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.snap        (snap),
		.hdr         (hdr)
	);

	mbrc_ram #(
		.WIDTH(16),
		.DEPTH(MAX_REGISTERS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (accept && item.mode),
		.raddr(item.word_index[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= accept && (item.mode || item.end_of_frame);
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready) begin
			is_read_s1 <= item.mode;
			oob_s1     <= item.word_index >= 7'(MAX_REGISTERS);
			snap_s1    <= snap;
		end
	end

	mbrc_judge u_judge (
		.snap      (snap_s1),
		.hdr       (hdr),
		.slave_addr(slave_cfg_q),
		.reg_count (expected_count_q),
		.status    (status),
		.exc_code  (exc_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_ok_q   <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1 && !is_read_s1) begin
				last_ok_q <= status == ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_read_s1) begin
				frame_status_q <= ST_OK;
				exc_byte_q     <= 8'd0;
				reg_word_q     <= oob_s1 ? 16'd0 : rd_data;
				words_valid_q  <= last_ok_q;
			end else begin
				frame_status_q <= status;
				exc_byte_q     <= exc_code;
				reg_word_q     <= 16'd0;
				words_valid_q  <= status == ST_OK;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frame_status = frame_status_q;
	assign result.exc_byte     = exc_byte_q;
	assign result.reg_word     = reg_word_q;
	assign result.words_valid  = words_valid_q;

	`MBRC_ASSERT_NEXT(a_read_enters_check, accept && item.mode, valid_s1 && is_read_s1)
	`MBRC_ASSERT_NEXT(a_check_holds_on_stall, valid_s1 && !adv, valid_s1)
	`MBRC_ASSERT_IMP(a_exc_code, out_valid_q && exc_byte_q != '0, frame_status_q == ST_EXCEPTION)
	`MBRC_ASSERT_IMP(a_fail_not_valid, out_valid_q && frame_status_q != ST_OK, !words_valid_q)

endmodule
